[hw/rtl/bole_pkg.sv]
// Shared types, codes and defaults for the bounded ordered list engine.
package bole_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ACTION_BITS    = 3;
  localparam int ITEM_BITS      = 32;
  localparam int STATUS_BITS    = 2;
  localparam int COUNT_OUT_BITS = 5;

  typedef logic [ACTION_BITS-1:0]    action_t;
  typedef logic [STATUS_BITS-1:0]    status_t;
  typedef logic [COUNT_OUT_BITS-1:0] count_out_t;
  typedef logic signed [ITEM_BITS-1:0] item_t;

  localparam action_t ACT_INS_TAIL = 3'd0;
  localparam action_t ACT_INS_HEAD = 3'd1;
  localparam action_t ACT_DELETE   = 3'd2;
  localparam action_t ACT_SEARCH   = 3'd3;
  localparam action_t ACT_REVERSE  = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // Per-cell load select; at most one bit set.
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

[hw/rtl/bole_in_if.sv]
// Input channel: action and operand value.
interface bole_in_if;
  import bole_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  item_t   item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

[hw/rtl/bole_out_if.sv]
// Output channel: match flag, status and entry count.
interface bole_out_if;
  import bole_pkg::*;

  logic       valid;
  logic       ready;
  logic       found;
  status_t    status;
  count_out_t entry_count;

  modport source (output valid, output found, output status, output entry_count, input ready);
  modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

[hw/rtl/bole_cell.sv]
// One list slot: value register, neighbor load mux and key compare.
module bole_cell #(
  parameter int VALUE_BITS = bole_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  bole_pkg::cell_ctl_t   ctl,
  input  logic [VALUE_BITS-1:0] new_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  input  logic [VALUE_BITS-1:0] key,
  input  logic                  occupied,
  output logic [VALUE_BITS-1:0] val,
  output logic                  match
);
  import bole_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      val <= new_val;
    end else if (ctl.take_left) begin
      val <= left_val;
    end else if (ctl.take_right) begin
      val <= right_val;
    end
  end

  assign match = occupied && (val == key);

endmodule

[hw/rtl/bole_prefix_or.sv]
// Log-depth prefix OR: pfx[i] = OR of vec[0..i].
module bole_prefix_or #(
  parameter int WIDTH = bole_pkg::DEPTH_DEF
) (
  input  logic [WIDTH-1:0] vec,
  output logic [WIDTH-1:0] pfx
);
  import bole_pkg::*;

  localparam int STAGES = $clog2(WIDTH);

  logic [WIDTH-1:0] lvl [STAGES+1];

  assign lvl[0] = vec;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      if (i >= (1 << s)) begin : g_or
        assign lvl[s+1][i] = lvl[s][i] | lvl[s][i-(1 << s)];
      end else begin : g_pass
        assign lvl[s+1][i] = lvl[s][i];
      end
    end
  end

  assign pfx = lvl[STAGES];

endmodule

[hw/rtl/bounded_ordered_list_engine.sv]
// Top level: ordered list held in a chain of cells, one action in flight.
// On acceptance the key is compared in all cells and the matches are registered; the
//   busy state then resolves the first match, shifts the chain and registers the result.
//   A new action is accepted only once that result has been applied.
// A stalled output holds the engine in its apply cycle until the result is taken.
// Reset (rst, synchronous): list empty, orientation normal, no result pending.
module bounded_ordered_list_engine #(
  parameter int DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = bole_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  bole_in_if.sink   in_ch,
  bole_out_if.source out_ch
);
  import bole_pkg::*;

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_BUSY = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  rev;
  action_t               op;
  logic [VALUE_BITS-1:0] op_val;
  logic [DEPTH-1:0]      match_vec;

  logic       out_valid;
  logic       out_found;
  status_t    out_status;
  count_out_t out_count;

  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      match_rev;
  logic [DEPTH-1:0]      lo_or;
  logic [DEPTH-1:0]      hi_rev;
  logic [DEPTH-1:0]      del_mask;
  cell_ctl_t             ctl [DEPTH];

  logic    in_fire;
  logic    apply;
  logic    empty;
  logic    full;
  logic    any_match;
  logic    phys_end;
  logic    do_ins;
  logic    do_del;
  logic    res_found;
  status_t res_status;

  // Operand sign-extended, then kept in VALUE_BITS.
  assign key = VALUE_BITS'(in_ch.item_value);

  assign in_ch.ready = (state == STATE_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign apply       = (state == STATE_BUSY) && (!out_valid || out_ch.ready);

  assign empty     = (count == '0);
  assign full      = (count == FULL_CNT);
  assign any_match = |match_vec;
  assign phys_end  = (op == ACT_INS_TAIL) != rev;
  assign do_ins    = apply && (op == ACT_INS_TAIL || op == ACT_INS_HEAD) && !full;
  assign do_del    = apply && (op == ACT_DELETE) && any_match;

  // First match from the head: lowest slot normally, highest slot when reversed.
  bole_prefix_or #(.WIDTH(DEPTH)) u_lo_or (.vec(match_vec), .pfx(lo_or));
  bole_prefix_or #(.WIDTH(DEPTH)) u_hi_or (.vec(match_rev), .pfx(hi_rev));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(i);
    logic                  rev_mask;
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    assign match_rev[i] = match_vec[DEPTH-1-i];

    // Reversed: slot i is at or past the match when no match sits above it.
    if (i == DEPTH - 1) begin : g_top
      assign rev_mask  = 1'b1;
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign rev_mask  = !hi_rev[DEPTH-2-i];
      assign right_val = cell_val[i+1];
    end

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_rest
      assign left_val = cell_val[i-1];
    end

    assign del_mask[i] = rev ? rev_mask : lo_or[i];

    always_comb begin
      ctl[i].take_new   = do_ins && (phys_end ? (IDX == count) : (i == 0));
      ctl[i].take_left  = do_ins && !phys_end && (i != 0);
      ctl[i].take_right = do_del && del_mask[i] && (i != DEPTH - 1);
    end

    bole_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .new_val   (op_val),
      .left_val  (left_val),
      .right_val (right_val),
      .key       (key),
      .occupied  (IDX < count),
      .val       (cell_val[i]),
      .match     (cell_match[i])
    );
  end

  always_comb begin
    res_found  = 1'b0;
    res_status = ST_OK;
    case (op) inside
      ACT_INS_TAIL, ACT_INS_HEAD: begin
        res_status = full ? ST_FULL : ST_OK;
      end
      ACT_DELETE, ACT_SEARCH: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (!any_match) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_found = 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_del) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      STATE_IDLE: begin
        if (in_fire) begin
          state_next = STATE_BUSY;
        end
      end
      STATE_BUSY: begin
        if (apply) begin
          state_next = STATE_IDLE;
        end
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      count     <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (apply && op == ACT_REVERSE && !empty) begin
        rev <= !rev;
      end
      if (apply) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op        <= in_ch.action;
      op_val    <= key;
      match_vec <= cell_match;
    end
    if (apply) begin
      out_found  <= res_found;
      out_status <= res_status;
      out_count  <= COUNT_OUT_BITS'(count_next);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.found       = out_found;
  assign out_ch.status      = out_status;
  assign out_ch.entry_count = out_count;

endmodule

[hw/rtl/bole_chk.sv]
// Port-level checker for the bounded ordered list engine, bound to the top level.
module bole_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   found,
  input bole_pkg::status_t      status,
  input bole_pkg::count_out_t   entry_count
);
  import bole_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK)
    else $error("match reported with non-ok status");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty status with nonzero count");

  // Only one action in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count)
);
